// ===== rtl/dsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsg_pkg
// Shared types and constants of the DSatur graph colouring core.
// ----------------------------------------------------------------------------
package dsg_pkg;

   localparam int unsigned NodeWidth  = 6;
   localparam int unsigned CountWidth = 7;

   typedef enum logic {
      OP_ADD_EDGE = 1'b0,
      OP_RUN      = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_INIT,
      ST_INIT_WAIT,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_PICK,
      ST_UPDATE,
      ST_UPDATE_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic edge_wr;
      logic clr_start;
      logic idx_reset;
      logic idx_step;
      logic init_rd;
      logic init_wr;
      logic scan_cmp;
      logic pick_rd;
      logic pick_set;
      logic upd_wr;
      logic best_clear;
   } cmd_type;

   typedef struct packed {
      logic idx_done;
      logic clr_busy;
      logic round_last;
   } status_type;

endpackage

// ===== rtl/dsg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsg_datapath
// Adjacency, colour and saturation stores with the scan, pick and update logic.
// ----------------------------------------------------------------------------
module dsg_datapath #(
   parameter int unsigned MAX_NODES = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dsg_pkg::cmd_type                       cmd,
   output dsg_pkg::status_type                    status,
   input  logic [dsg_pkg::NodeWidth-1:0]          edge_a,
   input  logic [dsg_pkg::NodeWidth-1:0]          edge_b,
   input  logic [dsg_pkg::CountWidth-1:0]         csr_node_count_ff,
   output logic [dsg_pkg::NodeWidth-1:0]          best_node,
   output logic [dsg_pkg::NodeWidth-1:0]          best_color
);

   localparam int unsigned IdxW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int unsigned CntW = $clog2(MAX_NODES + 1);

   logic [63:0] adj_mem [MAX_NODES];
   logic [63:0] ncs_mem [MAX_NODES];
   logic [6:0]  deg_mem [MAX_NODES];
   logic        colored_ff [MAX_NODES];

   logic [63:0] adj_rd_ff;
   logic [63:0] ncs_rd_ff;
   logic [6:0]  deg_rd_ff;
   logic        col_rd_ff;

   logic [CntW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] clr_ff, clr_in;
   logic [CntW-1:0] round_ff, round_in;
   logic [IdxW-1:0] rd_idx_ff;

   logic [IdxW-1:0] best_ff, best_in;
   logic [6:0]      best_sat_ff, best_sat_in;
   logic [6:0]      best_deg_ff, best_deg_in;
   logic            found_ff, found_in;
   logic [5:0]      color_ff, color_in;
   logic [63:0]     nb_ff, nb_in;

   logic [63:0] active;
   logic [IdxW-1:0] idx;
   logic [6:0]  pop_adj, pop_ncs, first_free;
   logic        ea_ok, eb_ok;

   assign idx = idx_ff[IdxW-1:0];

   always_comb begin
      active = '0;
      for (int i = 0; i < 64; i++) begin
         active[i] = (7'(i) < csr_node_count_ff);
      end
   end

   always_comb begin
      pop_adj = '0;
      pop_ncs = '0;
      for (int i = 0; i < 64; i++) begin
         pop_adj = pop_adj + 7'(adj_rd_ff[i] & active[i]);
         pop_ncs = pop_ncs + 7'(ncs_rd_ff[i]);
      end
   end

   always_comb begin
      first_free = 7'd63;
      for (int i = 62; i >= 0; i--) begin
         if (!ncs_rd_ff[i]) begin
            first_free = 7'(i);
         end
      end
   end

   assign ea_ok = (32'(edge_a) < MAX_NODES);
   assign eb_ok = (32'(edge_b) < MAX_NODES);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_reset) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + 1'b1;
      end
      clr_in = clr_ff;
      if (cmd.clr_start) begin
         clr_in = CntW'(MAX_NODES);
      end else if (clr_ff != '0) begin
         clr_in = clr_ff - 1'b1;
      end
      round_in = round_ff;
      if (cmd.init_rd && idx_ff == '0) begin
         round_in = '0;
      end else if (cmd.pick_set) begin
         round_in = round_ff + 1'b1;
      end
   end

   always_comb begin
      best_in     = best_ff;
      best_sat_in = best_sat_ff;
      best_deg_in = best_deg_ff;
      found_in    = found_ff;
      color_in    = color_ff;
      nb_in       = nb_ff;
      if (cmd.best_clear) begin
         found_in = 1'b0;
      end else if (cmd.scan_cmp && !col_rd_ff) begin
         if (!found_ff || pop_ncs > best_sat_ff ||
             (pop_ncs == best_sat_ff && deg_rd_ff > best_deg_ff)) begin
            found_in    = 1'b1;
            best_in     = rd_idx_ff;
            best_sat_in = pop_ncs;
            best_deg_in = deg_rd_ff;
         end
      end
      if (cmd.pick_set) begin
         color_in = first_free[5:0];
         nb_in    = adj_rd_ff & active;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         clr_ff   <= CntW'(MAX_NODES);
         round_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         clr_ff   <= clr_in;
         round_ff <= round_in;
         found_ff <= found_in;
      end
      best_ff     <= best_in;
      best_sat_ff <= best_sat_in;
      best_deg_ff <= best_deg_in;
      color_ff    <= color_in;
      nb_ff       <= nb_in;
   end

   // read port
   always_ff @(posedge clock) begin
      if (cmd.pick_rd) begin
         adj_rd_ff <= adj_mem[best_ff];
         ncs_rd_ff <= ncs_mem[best_ff];
         rd_idx_ff <= best_ff;
      end else begin
         adj_rd_ff <= adj_mem[idx];
         ncs_rd_ff <= ncs_mem[idx];
         deg_rd_ff <= deg_mem[idx];
         col_rd_ff <= colored_ff[idx];
         rd_idx_ff <= idx;
      end
   end

   // write port
   always_ff @(posedge clock) begin
      if (clr_ff != '0) begin
         adj_mem[IdxW'(clr_ff - 1'b1)] <= '0;
      end else if (cmd.edge_wr && ea_ok && eb_ok && edge_a != edge_b) begin
         adj_mem[IdxW'(edge_a)][edge_b] <= 1'b1;
         adj_mem[IdxW'(edge_b)][edge_a] <= 1'b1;
      end
      if (cmd.init_wr) begin
         ncs_mem[rd_idx_ff]    <= '0;
         deg_mem[rd_idx_ff]    <= pop_adj;
         colored_ff[rd_idx_ff] <= 1'b0;
      end else if (cmd.pick_set) begin
         colored_ff[best_ff] <= 1'b1;
      end else if (cmd.upd_wr && nb_ff[rd_idx_ff] && !col_rd_ff) begin
         ncs_mem[rd_idx_ff][color_ff] <= 1'b1;
         if (deg_rd_ff != '0) begin
            deg_mem[rd_idx_ff] <= deg_rd_ff - 1'b1;
         end
      end
   end

   assign status.idx_done   = (7'(idx_ff) >= csr_node_count_ff);
   assign status.clr_busy   = (clr_ff != '0);
   assign status.round_last = (7'(round_ff) >= csr_node_count_ff);
   assign best_node  = (dsg_pkg::NodeWidth)'(best_ff);
   assign best_color = color_ff;

endmodule

// ===== rtl/dsg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsg_ctrl
// Sequencer for edge loads, the colouring rounds and the clearing sweep.
// ----------------------------------------------------------------------------
module dsg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_last,
   output dsg_pkg::cmd_type     cmd,
   input  dsg_pkg::status_type  status
);

   dsg_pkg::state_type state_ff, state_in;
   logic req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsg_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_take = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rsp_last  = 1'b0;
      unique case (state_ff)
         dsg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_take) begin
               if (req_operation == dsg_pkg::OP_RUN) begin
                  cmd.idx_reset = 1'b1;
                  state_in = dsg_pkg::ST_INIT;
               end else begin
                  cmd.edge_wr = 1'b1;
               end
            end
         end
         dsg_pkg::ST_CLEAR: begin
            if (!status.clr_busy) begin
               state_in = dsg_pkg::ST_IDLE;
            end
         end
         dsg_pkg::ST_INIT: begin
            cmd.init_rd = 1'b1;
            if (status.idx_done) begin
               cmd.idx_reset  = 1'b1;
               cmd.best_clear = 1'b1;
               state_in = dsg_pkg::ST_SCAN;
            end else begin
               state_in = dsg_pkg::ST_INIT_WAIT;
            end
         end
         dsg_pkg::ST_INIT_WAIT: begin
            cmd.init_wr  = 1'b1;
            cmd.idx_step = 1'b1;
            state_in = dsg_pkg::ST_INIT;
         end
         dsg_pkg::ST_SCAN: begin
            if (status.idx_done) begin
               cmd.pick_rd = 1'b1;
               state_in = dsg_pkg::ST_PICK;
            end else begin
               cmd.idx_step = 1'b1;
               state_in = dsg_pkg::ST_SCAN_WAIT;
            end
         end
         dsg_pkg::ST_SCAN_WAIT: begin
            cmd.scan_cmp = 1'b1;
            state_in = dsg_pkg::ST_SCAN;
         end
         dsg_pkg::ST_PICK: begin
            cmd.pick_set  = 1'b1;
            cmd.idx_reset = 1'b1;
            state_in = dsg_pkg::ST_UPDATE;
         end
         dsg_pkg::ST_UPDATE: begin
            if (status.idx_done) begin
               state_in = dsg_pkg::ST_EMIT;
            end else begin
               cmd.idx_step = 1'b1;
               state_in = dsg_pkg::ST_UPDATE_WAIT;
            end
         end
         dsg_pkg::ST_UPDATE_WAIT: begin
            cmd.upd_wr = 1'b1;
            state_in = dsg_pkg::ST_UPDATE;
         end
         dsg_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last  = status.round_last;
            if (!rsp_stall) begin
               cmd.idx_reset  = 1'b1;
               cmd.best_clear = 1'b1;
               if (status.round_last) begin
                  cmd.clr_start = 1'b1;
                  state_in = dsg_pkg::ST_CLEAR;
               end else begin
                  state_in = dsg_pkg::ST_SCAN;
               end
            end
         end
         default: state_in = dsg_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/dsatur_graph_coloring_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsatur_graph_coloring_core
// DSatur greedy graph colouring with an edge loading and a run operation.
//
// Usage: an add-edge request (operation 0) sets both directions of the edge
// in the adjacency store. A run request (operation 1) colours nodes 0 to
// node_count-1; one response transfer per node carries node, colour and last
// (set on the final node). Each round scans every node once through the
// single store read port, then updates the neighbours. The request side
// stalls for the whole run. After reset and after every run the adjacency
// store is swept clear, one row a cycle, while requests stall. csr_node_count
// may be written at any idle time; 0 acts as 1, values above MAX_NODES
// saturate. A stalled response holds its value and stops the run until taken.
// ----------------------------------------------------------------------------
module dsatur_graph_coloring_core #(
   parameter int unsigned MAX_NODES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [5:0]  req_node_a,
   input  logic [5:0]  req_node_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_node,
   output logic [5:0]  rsp_color,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [6:0]  csr_node_count
);

   dsg_pkg::cmd_type    cmd;
   dsg_pkg::status_type status;
   logic [6:0] node_count_ff, node_count_in;

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_write) begin
         if (csr_node_count == '0) begin
            node_count_in = 7'd1;
         end else if (32'(csr_node_count) > MAX_NODES) begin
            node_count_in = 7'(MAX_NODES);
         end else begin
            node_count_in = csr_node_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 7'(MAX_NODES);
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   dsg_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_last      (rsp_last),
      .cmd           (cmd),
      .status        (status)
   );

   dsg_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .edge_a            (req_node_a),
      .edge_b            (req_node_b),
      .csr_node_count_ff (node_count_ff),
      .best_node         (rsp_node),
      .best_color        (rsp_color)
   );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DSatur graph colouring core.
//
// Edge loads and colouring runs go in through the request channel with
// random gaps, none in the steady phases. A scoreboard keeps its own
// adjacency copy and node count and works out each run's colouring order.
// Every response transfer is then checked against the oldest expected node.
// The node count is rewritten between phases, covering its extremes and the
// out-of-range values. One phase holds the response side off for a long
// stretch so that the run halts at a held response while requests stall.
// ----------------------------------------------------------------------------

class colouring_board;
   typedef struct {
      logic [5:0] node;
      logic [5:0] color;
      logic       last;
   } colouring_type;

   bit [63:0]     adjacency[64];
   int            node_total;
   colouring_type pending[$];
   int            errors;

   function new();
      foreach (adjacency[i]) adjacency[i] = '0;
      node_total = 64;
      errors     = 0;
   endfunction

   task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function void set_count(int value);
      value = value & 127;
      if (value < 1) value = 1;
      if (value > 64) value = 64;
      node_total = value;
   endfunction

   function void colour_graph();
      int            n;
      bit [63:0]     active;
      bit [6:0]      colour_of[64];
      bit [63:0]     seen[64];
      int            degree[64];
      int            best, best_sat, best_deg, sat, c;
      bit            found;
      colouring_type item;
      n = node_total;
      active = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      for (int i = 0; i < n; i++) begin
         colour_of[i] = 7'd64;
         seen[i]      = '0;
         degree[i]    = $countones(adjacency[i] & active);
      end
      for (int r = 0; r < n; r++) begin
         found = 0;
         best = 0;
         best_sat = 0;
         best_deg = 0;
         for (int i = 0; i < n; i++) begin
            if (colour_of[i] == 7'd64) begin
               sat = $countones(seen[i]);
               if (!found || sat > best_sat ||
                   (sat == best_sat && degree[i] > best_deg)) begin
                  found = 1;
                  best = i;
                  best_sat = sat;
                  best_deg = degree[i];
               end
            end
         end
         c = 0;
         while (c < 63 && seen[best][c]) c++;
         colour_of[best] = 7'(c);
         for (int i = 0; i < n; i++) begin
            if (adjacency[best][i] && active[i] && colour_of[i] == 7'd64) begin
               seen[i][c] = 1'b1;
               if (degree[i] > 0) degree[i]--;
            end
         end
         item.node  = 6'(best);
         item.color = 6'(c);
         item.last  = (r + 1 == n);
         pending.push_back(item);
      end
      foreach (adjacency[i]) adjacency[i] = '0;
   endfunction

   function void note_request(dsg_pkg::op_type op, bit [5:0] a, bit [5:0] b);
      if (op == dsg_pkg::OP_RUN) begin
         colour_graph();
      end else if (a != b) begin
         adjacency[a][b] = 1'b1;
         adjacency[b][a] = 1'b1;
      end
   endfunction

   task check_response(logic [5:0] node, logic [5:0] color, logic last);
      colouring_type want;
      if (pending.size() == 0) begin
         report($sformatf("unexpected transfer node %0d colour %0d", node, color));
      end else begin
         want = pending.pop_front();
         if (node !== want.node)
            report($sformatf("node %0d, want %0d", node, want.node));
         if (color !== want.color)
            report($sformatf("colour %0d, want %0d (node %0d)", color, want.color,
                             want.node));
         if (last !== want.last)
            report($sformatf("last %0b, want %0b (node %0d)", last, want.last,
                             want.node));
      end
   endtask
endclass

module tb;
   localparam int IdleLimit = 20000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_operation;
   logic [5:0] req_node_a;
   logic [5:0] req_node_b;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [5:0] rsp_node;
   logic [5:0] rsp_color;
   logic       rsp_last;
   logic       csr_write;
   logic [6:0] csr_node_count;

   colouring_board board;
   bit             steady;
   bit             hold_off;
   int             idle_cycles;
   int             sent;

   dsatur_graph_coloring_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_node       (rsp_node),
      .rsp_color      (rsp_color),
      .rsp_last       (rsp_last),
      .csr_write      (csr_write),
      .csr_node_count (csr_node_count)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_node, rsp_color, rsp_last);
      rsp_stall <= hold_off || (!steady && $urandom_range(99) < 38);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IdleLimit) begin
            $display("dsatur_graph_coloring_core test failed");
            $finish;
         end
      end
   end

   task send_item(dsg_pkg::op_type op, bit [5:0] a, bit [5:0] b);
      while (!steady && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_node_a    <= a;
      req_node_b    <= b;
      do @(posedge clock); while (req_stall);
      board.note_request(op, a, b);
      sent++;
   endtask

   // hold until every expected transfer is in and the clearing sweep is over
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task write_count(int value);
      csr_write      <= 1'b1;
      csr_node_count <= 7'(value);
      @(posedge clock);
      csr_write      <= 1'b0;
      board.set_count(value);
   endtask

   task edge_burst(int count, int n);
      bit [5:0] a, b;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 85) begin
            a = 6'($urandom_range(n - 1));
            b = 6'($urandom_range(n - 1));
         end else begin
            a = 6'($urandom);
            b = 6'($urandom);
         end
         send_item(dsg_pkg::OP_ADD_EDGE, a, b);
      end
   endtask

   initial begin
      int value, n, seq;
      board          = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = dsg_pkg::OP_ADD_EDGE;
      req_node_a     = '0;
      req_node_b     = '0;
      rsp_stall      = 1'b0;
      csr_write      = 1'b0;
      csr_node_count = '0;
      steady         = 0;
      hold_off       = 0;
      sent           = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (100) @(posedge clock);

      // full graph size from reset: extremes, self-loop, repeated edge
      send_item(dsg_pkg::OP_ADD_EDGE, 6'd0, 6'd63);
      send_item(dsg_pkg::OP_ADD_EDGE, 6'd63, 6'd0);
      send_item(dsg_pkg::OP_ADD_EDGE, 6'd5, 6'd5);
      send_item(dsg_pkg::OP_ADD_EDGE, 6'd62, 6'd63);
      send_item(dsg_pkg::OP_ADD_EDGE, 6'd0, 6'd62);
      send_item(dsg_pkg::OP_ADD_EDGE, 6'd21, 6'd42);
      send_item(dsg_pkg::OP_RUN, 6'd0, 6'd0);
      drain();

      // triangle plus an edge beyond the node count
      write_count(3);
      send_item(dsg_pkg::OP_ADD_EDGE, 6'd0, 6'd1);
      send_item(dsg_pkg::OP_ADD_EDGE, 6'd1, 6'd2);
      send_item(dsg_pkg::OP_ADD_EDGE, 6'd2, 6'd0);
      send_item(dsg_pkg::OP_ADD_EDGE, 6'd1, 6'd40);
      send_item(dsg_pkg::OP_RUN, 6'h3f, 6'h3f);
      drain();

      // zero acts as one node; run with its only edge beyond the node count
      write_count(0);
      send_item(dsg_pkg::OP_ADD_EDGE, 6'd0, 6'd1);
      send_item(dsg_pkg::OP_RUN, 6'd0, 6'd0);
      drain();

      // above the maximum saturates; star graph
      write_count(127);
      for (int i = 1; i < 8; i++) send_item(dsg_pkg::OP_ADD_EDGE, 6'd63, 6'(i));
      send_item(dsg_pkg::OP_RUN, 6'd0, 6'd0);
      drain();

      seq = 0;
      while (sent < 360) begin
         case ($urandom_range(19))
            0:       value = 64;
            1:       value = 0;
            2:       value = $urandom_range(127, 65);
            3:       value = 1;
            default: value = $urandom_range(16, 2);
         endcase
         write_count(value);
         n = board.node_total;
         steady = (seq >= 4 && seq < 8);
         if (seq == 10) begin
            fork
               begin
                  hold_off = 1;
                  repeat (400) @(posedge clock);
                  hold_off = 0;
               end
            join_none
            send_item(dsg_pkg::OP_RUN, 6'd0, 6'd0);
         end
         edge_burst($urandom_range(2 * n + 2), n);
         if ($urandom_range(9) == 0)
            send_item(dsg_pkg::OP_RUN, 6'($urandom), 6'($urandom));
         edge_burst($urandom_range(3), n);
         send_item(dsg_pkg::OP_RUN, 6'($urandom), 6'($urandom));
         drain();
         seq++;
      end
      steady = 0;

      drain();
      if (board.pending.size() != 0)
         board.report($sformatf("%0d transfers never arrived", board.pending.size()));
      if (board.errors == 0) begin
         $display("dsatur_graph_coloring_core test passed");
      end else begin
         $display("dsatur_graph_coloring_core test failed");
      end
      $finish;
   end
endmodule
